### src/lru_replacement_tracker_unit_assert.svh
`ifndef LRU_REPLACEMENT_TRACKER_UNIT_ASSERT_SVH
`define LRU_REPLACEMENT_TRACKER_UNIT_ASSERT_SVH

// same-cycle implication, checked only out of reset
`define LRT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked only out of reset
`define LRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/lrt_pkg.sv
package lrt_pkg;

    localparam int SLOTS  = 64;
    localparam int IDX_W  = $clog2(SLOTS);
    localparam int SLOT_W = 6;
    localparam int PAGE_W = 32;

    localparam logic CMD_ACCESS  = 1'b0;
    localparam logic CMD_REPLACE = 1'b1;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    typedef struct packed {
        logic              command;
        logic [SLOT_W-1:0] slot;
        logic [PAGE_W-1:0] page_id;
    } t_in_item;

    typedef struct packed {
        logic              victim_valid;
        logic [SLOT_W-1:0] victim_slot;
        logic [PAGE_W-1:0] victim_page_id;
        logic              status;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DETACH,
        ST_APPEND,
        ST_FINISH
    } t_state;

endpackage

### src/lrt_ram.sv
module lrt_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/lrt_out_stage.sv
module lrt_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lrt_pkg::t_out_item i_data,
    output logic              o_free,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output lrt_pkg::t_out_item o_out_data
);

    import lrt_pkg::*;

    logic      r_valid;
    t_out_item r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data <= i_data;
        end
    end

    assign o_free      = !r_valid || !i_out_stall;
    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

endmodule

### src/lru_replacement_tracker_unit.sv
// Flow: an in-range access passes through the detach, append and finish states,
// a replace or out-of-range access through detach and finish; o_out_valid rises
// once finish pushes into a free output register. A new transaction is taken
// only in idle, after the read, unlink and append passes over the link memories.
// Reset: synchronous active low; clears list order, linked flags and output
// valid. Link and page memories hold no reset value and need no clearing pass.
module lru_replacement_tracker_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  lrt_pkg::t_in_item  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output lrt_pkg::t_out_item o_out_data
);

    import lrt_pkg::*;

    t_state            r_state, n_state;
    logic              r_cmd;
    logic [IDX_W-1:0]  r_slot;
    logic              r_in_range;
    logic [IDX_W-1:0]  r_oldest, n_oldest;
    logic [IDX_W-1:0]  r_newest, n_newest;
    logic              r_empty, n_empty;
    logic [SLOTS-1:0]  r_linked, n_linked;
    t_out_item         r_res, n_res;

    logic              w_accept;
    logic [IDX_W-1:0]  w_raddr;
    logic              w_in_range;
    logic              w_detach;
    logic              w_is_old;
    logic              w_is_new;
    logic              w_middle;
    logic              w_out_free;
    logic              w_push;

    logic              mem_re;
    logic              next_we;
    logic [IDX_W-1:0]  next_waddr;
    logic [IDX_W-1:0]  next_wdata;
    logic [IDX_W-1:0]  next_rdata;
    logic              prev_we;
    logic [IDX_W-1:0]  prev_waddr;
    logic [IDX_W-1:0]  prev_wdata;
    logic [IDX_W-1:0]  prev_rdata;
    logic              page_we;
    logic              page_re;
    logic [PAGE_W-1:0] page_rdata;

    assign w_accept   = i_in_valid && (r_state == ST_IDLE);
    assign w_raddr    = (i_in_data.command == CMD_REPLACE) ? r_oldest
                                                           : i_in_data.slot[IDX_W-1:0];
    assign w_in_range = int'(i_in_data.slot) < SLOTS;

    assign w_detach = (r_cmd == CMD_ACCESS) ? (r_in_range && r_linked[r_slot]) : !r_empty;
    assign w_is_old = (r_slot == r_oldest);
    assign w_is_new = (r_slot == r_newest);
    assign w_middle = w_detach && !w_is_old && !w_is_new;

    lrt_ram #(.DEPTH(SLOTS), .WIDTH(IDX_W)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (next_we),
        .i_waddr (next_waddr),
        .i_wdata (next_wdata),
        .i_re    (mem_re),
        .i_raddr (w_raddr),
        .o_rdata (next_rdata)
    );

    lrt_ram #(.DEPTH(SLOTS), .WIDTH(IDX_W)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (prev_we),
        .i_waddr (prev_waddr),
        .i_wdata (prev_wdata),
        .i_re    (mem_re),
        .i_raddr (w_raddr),
        .o_rdata (prev_rdata)
    );

    lrt_ram #(.DEPTH(SLOTS), .WIDTH(PAGE_W)) u_page_ram (
        .i_clk   (i_clk),
        .i_we    (page_we),
        .i_waddr (w_raddr),
        .i_wdata (i_in_data.page_id),
        .i_re    (page_re),
        .i_raddr (w_raddr),
        .o_rdata (page_rdata)
    );

    lrt_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_data      (r_res),
        .o_free      (w_out_free),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_DETACH;
                end
            end
            ST_DETACH: begin
                if (r_cmd == CMD_ACCESS && r_in_range) begin
                    n_state = ST_APPEND;
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_APPEND: begin
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        mem_re     = 1'b0;
        page_we    = 1'b0;
        page_re    = 1'b0;
        next_we    = 1'b0;
        next_waddr = prev_rdata;
        next_wdata = next_rdata;
        prev_we    = 1'b0;
        prev_waddr = next_rdata;
        prev_wdata = prev_rdata;
        w_push     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                mem_re     = w_accept;
                page_we    = w_accept && (i_in_data.command == CMD_ACCESS) && w_in_range;
                page_re    = w_accept && (i_in_data.command == CMD_REPLACE);
            end
            ST_DETACH: begin
                next_we = w_middle;
                prev_we = w_middle;
            end
            ST_APPEND: begin
                next_we    = !r_empty;
                next_waddr = r_newest;
                next_wdata = r_slot;
                prev_we    = !r_empty;
                prev_waddr = r_slot;
                prev_wdata = r_newest;
            end
            ST_FINISH: begin
                w_push = w_out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_oldest = r_oldest;
        n_newest = r_newest;
        n_empty  = r_empty;
        n_linked = r_linked;
        n_res    = '0;
        case (r_state)
            ST_DETACH: begin
                if (w_detach) begin
                    if (w_is_old && w_is_new) begin
                        n_empty = 1'b1;
                    end else if (w_is_old) begin
                        n_oldest = next_rdata;
                    end else if (w_is_new) begin
                        n_newest = prev_rdata;
                    end
                    n_linked[r_slot] = 1'b0;
                end
                if (r_cmd == CMD_REPLACE) begin
                    if (r_empty) begin
                        n_res.status = STATUS_EMPTY;
                    end else begin
                        n_res.victim_valid   = 1'b1;
                        n_res.victim_slot    = SLOT_W'(r_slot);
                        n_res.victim_page_id = page_rdata;
                        n_res.status         = STATUS_OK;
                    end
                end
            end
            ST_APPEND: begin
                if (r_empty) begin
                    n_oldest = r_slot;
                    n_empty  = 1'b0;
                end
                n_newest         = r_slot;
                n_linked[r_slot] = 1'b1;
            end
            default: begin
                n_res = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_oldest <= '0;
            r_newest <= '0;
            r_empty  <= 1'b1;
            r_linked <= '0;
        end else begin
            r_state  <= n_state;
            r_oldest <= n_oldest;
            r_newest <= n_newest;
            r_empty  <= n_empty;
            r_linked <= n_linked;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd      <= i_in_data.command;
            r_slot     <= w_raddr;
            r_in_range <= w_in_range;
        end
        if (r_state == ST_DETACH) begin
            r_res <= n_res;
        end
    end

endmodule

### src/lrt_checker.sv
`include "lru_replacement_tracker_unit_assert.svh"

module lrt_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input lrt_pkg::t_in_item  i_in_data,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input lrt_pkg::t_out_item o_out_data
);

    import lrt_pkg::*;

    `LRT_ASSERT_NOW(a_victim_xor_error, i_clk, i_rst_n, o_out_valid, !(o_out_data.victim_valid && o_out_data.status == STATUS_EMPTY), "victim and empty error reported together")
    `LRT_ASSERT_NOW(a_no_victim_zero, i_clk, i_rst_n, o_out_valid && !o_out_data.victim_valid, o_out_data.victim_slot == '0 && o_out_data.victim_page_id == '0, "nonzero victim fields without a victim")
    `LRT_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "second transaction taken while one is in flight")
    `LRT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data), "stalled result changed")

endmodule

bind lru_replacement_tracker_unit lrt_checker u_lrt_checker (.*);

### tb/lru_replacement_tracker_unit_test.sv
module lru_replacement_tracker_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lrt_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RANDOM_ITEMS = 1525;
    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = 12;

    class lru_victim_tracker;
        logic [SLOT_W-1:0] newer_of [SLOTS];
        logic [SLOT_W-1:0] older_of [SLOTS];
        bit                in_list  [SLOTS];
        logic [PAGE_W-1:0] page_of  [SLOTS];
        logic [SLOT_W-1:0] oldest;
        logic [SLOT_W-1:0] newest;
        bit                empty;
        t_out_item         pending_victims [$];
        int                mismatches;

        function new();
            foreach (in_list[s]) begin
                in_list[s]  = 1'b0;
                newer_of[s] = '0;
                older_of[s] = '0;
                page_of[s]  = '0;
            end
            oldest     = '0;
            newest     = '0;
            empty      = 1'b1;
            mismatches = 0;
        endfunction

        function void unlink(logic [SLOT_W-1:0] s);
            if (s == oldest && s == newest) begin
                empty = 1'b1;
            end else if (s == oldest) begin
                oldest = newer_of[s];
            end else if (s == newest) begin
                newest = older_of[s];
            end else begin
                newer_of[older_of[s]] = newer_of[s];
                older_of[newer_of[s]] = older_of[s];
            end
            in_list[s] = 1'b0;
        endfunction

        function void link_newest(logic [SLOT_W-1:0] s);
            if (empty) begin
                oldest = s;
                newest = s;
                empty  = 1'b0;
            end else begin
                newer_of[newest] = s;
                older_of[s]      = newest;
                newest           = s;
            end
            in_list[s] = 1'b1;
        endfunction

        function void record_command(t_in_item cmd);
            t_out_item         res;
            logic [SLOT_W-1:0] victim;
            res = '0;
            if (cmd.command == CMD_ACCESS) begin
                page_of[cmd.slot] = cmd.page_id;
                if (in_list[cmd.slot]) begin
                    unlink(cmd.slot);
                end
                link_newest(cmd.slot);
                res.status = STATUS_OK;
            end else if (empty) begin
                res.status = STATUS_EMPTY;
            end else begin
                victim             = oldest;
                res.victim_valid   = 1'b1;
                res.victim_slot    = victim;
                res.victim_page_id = page_of[victim];
                res.status         = STATUS_OK;
                unlink(victim);
                page_of[victim] = '0;
            end
            pending_victims.push_back(res);
        endfunction

        function void report(string what, logic [63:0] want, logic [63:0] got);
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch %s: expected %h, got %h", what, want, got);
            end
        endfunction

        function void compare_victim(t_out_item got);
            t_out_item want;
            if (pending_victims.size() == 0) begin
                report("unexpected transaction", '0, 64'(got));
                return;
            end
            want = pending_victims.pop_front();
            if (got.victim_valid !== want.victim_valid) begin
                report("victim_valid", 64'(want.victim_valid), 64'(got.victim_valid));
            end
            if (got.victim_slot !== want.victim_slot) begin
                report("victim_slot", 64'(want.victim_slot), 64'(got.victim_slot));
            end
            if (got.victim_page_id !== want.victim_page_id) begin
                report("victim_page_id", 64'(want.victim_page_id),
                       64'(got.victim_page_id));
            end
            if (got.status !== want.status) begin
                report("status", 64'(want.status), 64'(got.status));
            end
        endfunction
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_data;

    lru_victim_tracker tracker = new();
    bit holding_off = 1'b0;
    int burst_left  = 0;
    int idle_cycles = 0;

    lru_replacement_tracker_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic t_in_item cmd_item(logic command, logic [SLOT_W-1:0] slot,
                                          logic [PAGE_W-1:0] page);
        t_in_item it;
        it.command = command;
        it.slot    = slot;
        it.page_id = page;
        return it;
    endfunction

    task automatic offer_command(input t_in_item cmd);
        i_in_valid <= 1'b1;
        i_in_data  <= cmd;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        tracker.record_command(cmd);
    endtask

    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (holding_off) begin
            gap = 0;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic run_directed();
        t_in_item plan [$];
        plan.push_back(cmd_item(CMD_REPLACE, 6'd0,  32'h0000_0000));
        plan.push_back(cmd_item(CMD_ACCESS,  6'd0,  32'h0000_0000));
        plan.push_back(cmd_item(CMD_ACCESS,  6'd63, 32'hffff_ffff));
        plan.push_back(cmd_item(CMD_ACCESS,  6'd0,  32'h5555_aaaa));
        plan.push_back(cmd_item(CMD_ACCESS,  6'd21, 32'haaaa_5555));
        plan.push_back(cmd_item(CMD_ACCESS,  6'd0,  32'h1234_5678));
        plan.push_back(cmd_item(CMD_ACCESS,  6'd0,  32'h8765_4321));
        plan.push_back(cmd_item(CMD_ACCESS,  6'd42, 32'h0f0f_0f0f));
        plan.push_back(cmd_item(CMD_REPLACE, 6'd63, 32'hffff_ffff));
        plan.push_back(cmd_item(CMD_REPLACE, 6'd0,  32'h0000_0000));
        plan.push_back(cmd_item(CMD_REPLACE, 6'd42, 32'h5a5a_5a5a));
        plan.push_back(cmd_item(CMD_REPLACE, 6'd21, 32'ha5a5_a5a5));
        plan.push_back(cmd_item(CMD_REPLACE, 6'd63, 32'hffff_ffff));
        plan.push_back(cmd_item(CMD_ACCESS,  6'd7,  32'hf0f0_f0f0));
        plan.push_back(cmd_item(CMD_ACCESS,  6'd7,  32'h7fff_ffff));
        plan.push_back(cmd_item(CMD_REPLACE, 6'd0,  32'h0000_0000));
        plan.push_back(cmd_item(CMD_REPLACE, 6'd0,  32'h0000_0000));
        plan.push_back(cmd_item(CMD_ACCESS,  6'd5,  32'h8000_0000));
        plan.push_back(cmd_item(CMD_ACCESS,  6'd6,  32'h0000_0001));
        plan.push_back(cmd_item(CMD_REPLACE, 6'd0,  32'h0000_0000));
        plan.push_back(cmd_item(CMD_ACCESS,  6'd5,  32'hc3c3_c3c3));
        plan.push_back(cmd_item(CMD_REPLACE, 6'd0,  32'h0000_0000));
        plan.push_back(cmd_item(CMD_REPLACE, 6'd0,  32'h0000_0000));
        plan.push_back(cmd_item(CMD_REPLACE, 6'd0,  32'h0000_0000));
        foreach (plan[k]) begin
            offer_command(plan[k]);
            pace_sender();
        end
    endtask

    task automatic run_random(int count);
        int       mode;
        int       share;
        int       pick;
        t_in_item cmd;
        mode = 0;
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0) begin
                mode = $urandom_range(0, 3);
            end
            case (mode)
                0:       share = 85;
                1:       share = 25;
                default: share = 55;
            endcase
            cmd.command = ($urandom_range(0, 99) < share) ? CMD_ACCESS : CMD_REPLACE;
            cmd.slot    = ($urandom_range(0, 3) == 0) ? SLOT_W'($urandom_range(0, 7))
                                                      : SLOT_W'($urandom_range(0, SLOTS - 1));
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                cmd.page_id = '0;
            end else if (pick == 1) begin
                cmd.page_id = '1;
            end else begin
                cmd.page_id = $urandom;
            end
            offer_command(cmd);
            pace_sender();
        end
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        run_random(RANDOM_ITEMS);
        i_in_valid <= 1'b0;
        while (tracker.pending_victims.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.pending_victims.size() == 0) begin
            $display("lru_replacement_tracker_unit verification clean");
        end else begin
            $display("lru_replacement_tracker_unit verification failed");
        end
        $finish;
    end

    initial begin
        int seg;
        int mode;
        int len;
        int period;
        i_out_stall <= 1'b0;
        seg = 0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) begin
            @(posedge i_clk);
        end
        forever begin
            seg++;
            if (seg == 8 || seg % 60 == 0) begin
                holding_off = 1'b1;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                holding_off = 1'b0;
            end else begin
                mode   = $urandom_range(0, 2);
                len    = $urandom_range(4, 60);
                period = $urandom_range(2, 7);
                for (int c = 0; c < len; c++) begin
                    case (mode)
                        0:       i_out_stall <= 1'b0;
                        1:       i_out_stall <= ($urandom_range(0, 1) == 1);
                        default: i_out_stall <= (c % period) != 0;
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            tracker.compare_victim(o_out_data);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("lru_replacement_tracker_unit verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

### lru_replacement_tracker_unit.f
+incdir+src
src/lrt_pkg.sv
src/lrt_ram.sv
src/lrt_out_stage.sv
src/lru_replacement_tracker_unit.sv
src/lrt_checker.sv
tb/lru_replacement_tracker_unit_test.sv
